[hdl/vnf_pkg.sv]
// Shared constants and types for the fractal value noise block.
// Used by vnf_setup, vnf_octave and value_noise_fbm_2d; depends on nothing.
`default_nettype none

package vnf_pkg;

	localparam int MAX_OCTAVES_DEF     = 8;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// Hash multipliers and the per-octave seed step.
	localparam logic [31:0] HASH_A    = 32'h9E3779B9;
	localparam logic [31:0] HASH_B    = 32'h85EBCA6B;
	localparam logic [31:0] HASH_C    = 32'h7FEB352D;
	localparam logic [31:0] HASH_D    = 32'h846CA68B;
	localparam int          SEED_STEP = 1013;

	// Three in Q2.16, used by the smoothstep fade.
	localparam logic [17:0] FADE_THREE = 18'd196608;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Configuration register map.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OCTAVES = 2'd0,
		REG_PERSIST = 2'd1,
		REG_LACUN   = 2'd2
	} cfg_reg_t;

	localparam logic [3:0]  OCTAVES_RST = 4'd2;
	localparam logic [16:0] PERSIST_RST = 17'd36045;
	localparam logic [10:0] LACUN_RST   = 11'd512;

	// Pipeline depth: stages inside an octave lane and in the whole block.
	localparam int LANE_STAGES = 10;
	localparam int PIPE_STAGES = 14;

endpackage

`default_nettype wire

[hdl/value_noise_fbm_2d.sv]
// Fractal 2D value noise: a signed fixed-point coordinate and a seed in,
// a normalised Q0.16 sample out. Uses vnf_pkg, vnf_setup and vnf_octave.
//
// Usage:
// - Input channel (in_valid/in_ready) carries coord_x, coord_y and noise_seed;
//   output channel (out_valid/out_ready) carries noise_value, one per item.
// - Every octave has its own lane, so one item is accepted per cycle and one
//   result leaves per cycle while out_ready stays high.
// - Each stage carries a valid bit and holds when the stage after it is full
//   and stalled, so a stalled receiver backs the pipeline up stage by stage;
//   in_ready stays high while any stage still has room.
// - After reset and after every configuration write the block rebuilds its
//   octave tables and then the amplitude reciprocal. in_ready is low during
//   that time.
// - Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   write them only while no item is in flight. Unknown indexes set no register but still restart the rebuild.
// - The final division by the amplitude sum is a multiply by the reciprocal
//   followed by one correction step.
`default_nettype none

module value_noise_fbm_2d #(
	parameter int MAX_OCTAVES     = vnf_pkg::MAX_OCTAVES_DEF,
	parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [vnf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [vnf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [31:0]              coord_x,
	input  wire logic signed [31:0]              coord_y,
	input  wire logic [31:0]                     noise_seed,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [15:0]                          noise_value
);

	localparam int LOG_OCT = $clog2(MAX_OCTAVES);
	localparam int NORM_W  = 17 + LOG_OCT;
	localparam int SUM_W   = 32 + LOG_OCT;
	localparam int RCP_W   = SUM_W - 15;
	localparam int NS      = vnf_pkg::PIPE_STAGES;
	localparam int LS      = vnf_pkg::LANE_STAGES;

	logic [47:0]       freq_tab [MAX_OCTAVES];
	logic [16:0]       wt_tab [MAX_OCTAVES];
	logic [NORM_W-1:0] norm;
	logic [RCP_W-1:0]  recip;
	logic              setup_done;

	vnf_setup #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.freq_tab  (freq_tab),
		.wt_tab    (wt_tab),
		.norm      (norm),
		.recip     (recip),
		.done      (setup_done)
	);

	// Stage valid bits and load enables; a stage loads when it is empty or
	// the stage after it loads.
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1] && setup_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid && setup_done;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Octave lanes, stages 1 to 10.
	logic [31:0] lane_prod [MAX_OCTAVES];

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		vnf_octave #(
			.OCT             (i),
			.COORD_FRAC_BITS (COORD_FRAC_BITS)
		) u_octave (
			.clk        (clk),
			.en         (en[LS:1]),
			.coord_x    (coord_x),
			.coord_y    (coord_y),
			.noise_seed (noise_seed),
			.freq       (freq_tab[i]),
			.weight     (wt_tab[i]),
			.prod       (lane_prod[i])
		);
	end

	// Stage 11: weighted sum over the octaves.
	logic [SUM_W-1:0] sum_n;
	logic [SUM_W-1:0] sum_s11;

	always_comb begin
		sum_n = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			sum_n = sum_n + SUM_W'(lane_prod[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			sum_s11 <= sum_n;
		end
	end

	// Stage 12: estimate of the quotient through the reciprocal.
	logic [SUM_W+RCP_W-1:0] mq_s12;
	logic [SUM_W-1:0]       sum_s12;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			mq_s12  <= {{RCP_W{1'b0}}, sum_s11} * {{SUM_W{1'b0}}, recip};
			sum_s12 <= sum_s11;
		end
	end

	// Stage 13: back-multiply the estimate, which is exact or one too low.
	logic [15:0]            qe;
	logic [NORM_W+15:0]     qn_s13;
	logic [15:0]            qe_s13;
	logic [SUM_W-1:0]       sum_s13;

	assign qe = mq_s12[SUM_W+15:SUM_W];

	always_ff @(posedge clk) begin
		if (en[13]) begin
			qn_s13  <= {{NORM_W{1'b0}}, qe} * {16'd0, norm};
			qe_s13  <= qe;
			sum_s13 <= sum_s12;
		end
	end

	// Stage 14: correction and output register.
	logic [SUM_W-1:0] rem_n;
	logic [15:0]      q_s14;

	assign rem_n = sum_s13 - qn_s13[SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (en[14]) begin
			q_s14 <= qe_s13 + 16'(rem_n >= SUM_W'(norm));
		end
	end

	assign out_valid   = vld_q[NS];
	assign noise_value = q_s14;

	// An item is only taken once the tables and reciprocal are complete.
	a_accept_after_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> setup_done)
		else $error("item accepted while octave tables were being rebuilt");

	// A configuration write restarts the table build and closes the input.
	a_cfg_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input still open after a configuration write");

	// The reciprocal estimate is never more than one below the true quotient.
	a_quotient_estimate: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[13] |-> rem_n < {norm, 1'b0})
		else $error("reciprocal quotient estimate out of range");

	// A full stage that cannot move on keeps its item.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[13] && !en[13] |=> vld_q[13])
		else $error("stalled item dropped from stage thirteen");

	// A finished reciprocal is never zero, since the amplitude sum is bounded.
	a_recip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		setup_done |-> recip != '0)
		else $error("reciprocal of the amplitude sum is zero");

endmodule

`default_nettype wire

[hdl/vnf_setup.sv]
// Configuration registers and the per-octave table builder of the noise block.
// Builds frequency and weight tables and the normalising reciprocal; uses vnf_pkg.
`default_nettype none

module vnf_setup #(
	parameter int MAX_OCTAVES = vnf_pkg::MAX_OCTAVES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [vnf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [vnf_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [47:0]                                freq_tab [MAX_OCTAVES],
	output logic [16:0]                                wt_tab [MAX_OCTAVES],
	output logic [17+$clog2(MAX_OCTAVES)-1:0]          norm,
	output logic [32+$clog2(MAX_OCTAVES)-15-1:0]       recip,
	output logic                                       done
);

	localparam int LOG_OCT = $clog2(MAX_OCTAVES);
	localparam int NORM_W  = 17 + LOG_OCT;
	localparam int SUM_W   = 32 + LOG_OCT;
	localparam int RCP_W   = SUM_W - 15;
	localparam int NW      = $clog2(MAX_OCTAVES + 1);
	localparam int IDX_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int DIV_W   = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {ST_TABLE, ST_DIV, ST_DONE} state_t;

	state_t              state_q;
	logic [3:0]          octaves_q;
	logic [16:0]         persist_q;
	logic [10:0]         lacun_q;
	logic [NW-1:0]       cnt_q;
	logic [DIV_W-1:0]    div_cnt_q;
	logic [63:0]         freq_q;
	logic [16:0]         amp_q;
	logic [NORM_W-1:0]   norm_q;
	logic [NORM_W:0]     rem_q;
	logic [RCP_W-1:0]    recip_q;

	logic [NW-1:0]       n_eff;
	logic [16:0]         p_sat;
	logic [16:0]         wt_n;
	logic [33:0]         amp_prod;
	logic [74:0]         freq_prod;
	logic [NORM_W:0]     div_try;
	logic                div_ge;

	always_comb begin
		if (octaves_q == 4'd0) begin
			n_eff = NW'(1);
		end else if (32'(octaves_q) > MAX_OCTAVES) begin
			n_eff = NW'(MAX_OCTAVES);
		end else begin
			n_eff = NW'(octaves_q);
		end
	end

	assign p_sat     = (persist_q > vnf_pkg::ONE_Q16) ? vnf_pkg::ONE_Q16 : persist_q;
	assign wt_n      = (cnt_q < n_eff) ? amp_q : 17'd0;
	assign amp_prod  = {17'd0, amp_q} * {17'd0, p_sat};
	assign freq_prod = {11'd0, freq_q} * {64'd0, lacun_q};

	// Restoring division of 2^SUM_W by the amplitude sum, one bit per cycle.
	assign div_try = {rem_q[NORM_W-1:0], (div_cnt_q == DIV_W'(0))};
	assign div_ge  = div_try >= {1'b0, norm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_TABLE;
			octaves_q <= vnf_pkg::OCTAVES_RST;
			persist_q <= vnf_pkg::PERSIST_RST;
			lacun_q   <= vnf_pkg::LACUN_RST;
			cnt_q     <= '0;
			div_cnt_q <= '0;
			freq_q    <= 64'd65536;
			amp_q     <= vnf_pkg::ONE_Q16;
			norm_q    <= '0;
			rem_q     <= '0;
			recip_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vnf_pkg::REG_OCTAVES: octaves_q <= cfg_data[3:0];
				vnf_pkg::REG_PERSIST: persist_q <= cfg_data;
				vnf_pkg::REG_LACUN:   lacun_q   <= cfg_data[10:0];
				default: ;
			endcase
			state_q   <= ST_TABLE;
			cnt_q     <= '0;
			div_cnt_q <= '0;
			freq_q    <= 64'd65536;
			amp_q     <= vnf_pkg::ONE_Q16;
			norm_q    <= '0;
			rem_q     <= '0;
			recip_q   <= '0;
		end else begin
			unique case (state_q)
				ST_TABLE: begin
					norm_q <= norm_q + NORM_W'(wt_n);
					amp_q  <= amp_prod[32:16];
					freq_q <= freq_prod[71:8];
					cnt_q  <= cnt_q + NW'(1);
					if (cnt_q == NW'(MAX_OCTAVES - 1)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= div_ge ? (div_try - {1'b0, norm_q}) : div_try;
					recip_q   <= {recip_q[RCP_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q + DIV_W'(1);
					if (div_cnt_q == DIV_W'(SUM_W)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: ;
				default: state_q <= ST_TABLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TABLE && !cfg_we) begin
			freq_tab[cnt_q[IDX_W-1:0]] <= freq_q[47:0];
			wt_tab[cnt_q[IDX_W-1:0]]   <= wt_n;
		end
	end

	assign norm  = norm_q;
	assign recip = recip_q;
	assign done  = (state_q == ST_DONE);

endmodule

`default_nettype wire

[hdl/vnf_octave.sv]
// One octave lane: scaling, lattice hashing, fade, bilinear blend and weighting.
// Ten register stages advanced by the enables of the enclosing pipeline; uses vnf_pkg.
`default_nettype none

module vnf_octave #(
	parameter int OCT             = 0,
	parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic [vnf_pkg::LANE_STAGES-1:0]    en,
	input  wire logic signed [31:0]                 coord_x,
	input  wire logic signed [31:0]                 coord_y,
	input  wire logic [31:0]                        noise_seed,
	input  wire logic [47:0]                        freq,
	input  wire logic [16:0]                        weight,
	output logic [31:0]                             prod
);

	localparam logic [31:0] SEED_OFS = 32'(OCT * vnf_pkg::SEED_STEP);
	localparam int F = COORD_FRAC_BITS;

	// Stage 1: partial products of coordinate times frequency.
	logic signed [56:0] xlo, ylo;
	logic [47:0]        xhi, yhi;
	logic [47:0]        xlo_s1, ylo_s1;
	logic [23:0]        xhi_s1, yhi_s1;
	logic [31:0]        sd_s1;

	assign xlo = coord_x * $signed({1'b0, freq[23:0]});
	assign ylo = coord_y * $signed({1'b0, freq[23:0]});
	assign xhi = {24'd0, coord_x[23:0]} * {24'd0, freq[47:24]};
	assign yhi = {24'd0, coord_y[23:0]} * {24'd0, freq[47:24]};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xlo_s1 <= xlo[47:0];
			ylo_s1 <= ylo[47:0];
			xhi_s1 <= xhi[23:0];
			yhi_s1 <= yhi[23:0];
			sd_s1  <= noise_seed + SEED_OFS;
		end
	end

	// Stage 2: scaled coordinate, lattice cell and fraction.
	logic [47:0] xsum, ysum;
	logic [31:0] sx, sy;
	logic [15:0] tx, ty;
	logic [31:0] x0_s2, y0_s2, sd_s2;
	logic [15:0] tx_s2, ty_s2;

	assign xsum = xlo_s1 + {xhi_s1, 24'd0};
	assign ysum = ylo_s1 + {yhi_s1, 24'd0};
	assign sx   = xsum[47:16];
	assign sy   = ysum[47:16];

	if (F >= 16) begin : g_frac_trunc
		assign tx = sx[F-1 -: 16];
		assign ty = sy[F-1 -: 16];
	end else begin : g_frac_shift
		assign tx = {sx[F-1:0], {(16-F){1'b0}}};
		assign ty = {sy[F-1:0], {(16-F){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x0_s2 <= 32'($signed(sx) >>> F);
			y0_s2 <= 32'($signed(sy) >>> F);
			tx_s2 <= tx;
			ty_s2 <= ty;
			sd_s2 <= sd_s1;
		end
	end

	// Stage 3: first hash products and the square of the fraction.
	logic [31:0] sqx, sqy;
	logic [31:0] xa_s3, yb_s3, sd_s3;
	logic [15:0] t2x_s3, t2y_s3;
	logic [17:0] kx_s3, ky_s3;

	assign sqx = {16'd0, tx_s2} * {16'd0, tx_s2};
	assign sqy = {16'd0, ty_s2} * {16'd0, ty_s2};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			xa_s3  <= 32'(x0_s2 * vnf_pkg::HASH_A);
			yb_s3  <= 32'(y0_s2 * vnf_pkg::HASH_B);
			t2x_s3 <= sqx[31:16];
			t2y_s3 <= sqy[31:16];
			kx_s3  <= vnf_pkg::FADE_THREE - {1'b0, tx_s2, 1'b0};
			ky_s3  <= vnf_pkg::FADE_THREE - {1'b0, ty_s2, 1'b0};
			sd_s3  <= sd_s2;
		end
	end

	// Stage 4: corner mixes, first hash multiply and the fade.
	// The next cell's product is the current one plus the multiplier itself.
	logic [31:0] xa1, yb1;
	logic [31:0] mix [4];
	logic [33:0] fpx, fpy;
	logic [31:0] h1_s4 [4];
	logic [15:0] fx_s4, fy_s4;

	assign xa1 = xa_s3 + vnf_pkg::HASH_A;
	assign yb1 = yb_s3 + vnf_pkg::HASH_B;
	assign mix[0] = sd_s3 ^ xa_s3 ^ yb_s3;
	assign mix[1] = sd_s3 ^ xa1 ^ yb_s3;
	assign mix[2] = sd_s3 ^ xa_s3 ^ yb1;
	assign mix[3] = sd_s3 ^ xa1 ^ yb1;
	assign fpx = {18'd0, t2x_s3} * {16'd0, kx_s3};
	assign fpy = {18'd0, t2y_s3} * {16'd0, ky_s3};

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int c = 0; c < 4; c++) begin
				h1_s4[c] <= 32'((mix[c] ^ (mix[c] >> 16)) * vnf_pkg::HASH_C);
			end
			fx_s4 <= fpx[31:16];
			fy_s4 <= fpy[31:16];
		end
	end

	// Stage 5: second hash multiply.
	logic [31:0] h2_s5 [4];
	logic [15:0] fx_s5, fy_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < 4; c++) begin
				h2_s5[c] <= 32'((h1_s4[c] ^ (h1_s4[c] >> 15)) * vnf_pkg::HASH_D);
			end
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
		end
	end

	// Stage 6: the final xorshift leaves the upper half unchanged, so the
	// corner value is simply the upper half; blend products along x.
	logic signed [16:0] dx0, dx1;
	logic signed [33:0] px0, px1;
	logic signed [33:0] px0_s6, px1_s6;
	logic [15:0]        a0_s6, a1_s6, fy_s6;

	assign dx0 = $signed({1'b0, h2_s5[1][31:16]}) - $signed({1'b0, h2_s5[0][31:16]});
	assign dx1 = $signed({1'b0, h2_s5[3][31:16]}) - $signed({1'b0, h2_s5[2][31:16]});
	assign px0 = dx0 * $signed({1'b0, fx_s5});
	assign px1 = dx1 * $signed({1'b0, fx_s5});

	always_ff @(posedge clk) begin
		if (en[5]) begin
			px0_s6 <= px0;
			px1_s6 <= px1;
			a0_s6  <= h2_s5[0][31:16];
			a1_s6  <= h2_s5[2][31:16];
			fy_s6  <= fy_s5;
		end
	end

	// Stage 7: x blends; the floored quotient's low half is bits 31:16.
	logic [15:0] bx0_s7, bx1_s7, fy_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			bx0_s7 <= a0_s6 + px0_s6[31:16];
			bx1_s7 <= a1_s6 + px1_s6[31:16];
			fy_s7  <= fy_s6;
		end
	end

	// Stage 8: blend product along y.
	logic signed [16:0] dy;
	logic signed [33:0] py;
	logic signed [33:0] py_s8;
	logic [15:0]        bx0_s8;

	assign dy = $signed({1'b0, bx1_s7}) - $signed({1'b0, bx0_s7});
	assign py = dy * $signed({1'b0, fy_s7});

	always_ff @(posedge clk) begin
		if (en[7]) begin
			py_s8  <= py;
			bx0_s8 <= bx0_s7;
		end
	end

	// Stage 9: octave noise value.
	logic [15:0] v_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			v_s9 <= bx0_s8 + py_s8[31:16];
		end
	end

	// Stage 10: weighted by the octave amplitude (zero for unused octaves).
	logic [32:0] pw;
	logic [31:0] prod_s10;

	assign pw = {17'd0, v_s9} * {16'd0, weight};

	always_ff @(posedge clk) begin
		if (en[9]) begin
			prod_s10 <= pw[31:0];
		end
	end

	assign prod = prod_s10;

endmodule

`default_nettype wire
